// File: design/cffp_pkg.sv
// ----------------------------------------------------------------------------
// cffp_pkg: shared types and constants of the colon field frame parser
// Holds the phase encoding, result kinds, error codes, register indexes and
// the result record passed from the parse stage to the output buffer.
// ----------------------------------------------------------------------------
package cffp_pkg;

   // Buffer sizes of the surrounding system; they bound the accepted fields.
   localparam int NAME_BYTES = 128;   // range 2..128
   localparam int DATA_BYTES = 1024;  // range 1..1024

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int RSP_DATA_WIDTH  = 48;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SOURCE_LIMIT = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DATA_LIMIT   = 4'd1;

   localparam logic [6:0] SOURCE_LIMIT_RESET = 7'd99;
   localparam logic [9:0] DATA_LIMIT_RESET   = 10'd1000;

   localparam logic [7:0]  SEPARATOR = 8'h3A;  // ':'
   localparam logic [19:0] TYPE_MAX  = 20'd65535;

   localparam logic [1:0] KIND_SOURCE = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_HEADER = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [1:0] ERR_NON_DIGIT   = 2'd0;
   localparam logic [1:0] ERR_OVER_LIMIT  = 2'd1;
   localparam logic [1:0] ERR_SOURCE_LONG = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_TYPE   = 5'b00010,
      PH_SIZE   = 5'b00100,
      PH_SOURCE = 5'b01000,
      PH_DATA   = 5'b10000
   } cffp_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_out;
      logic [15:0] msg_type;
      logic [9:0]  payload_size;
      logic [6:0]  source_length;
      logic [1:0]  error_code;
      logic        frame_last;
   } cffp_result_type;

endpackage

// File: design/cffp_csr.sv
// ----------------------------------------------------------------------------
// cffp_csr: configuration registers
// Holds the source length limit and the payload size limit.
// ----------------------------------------------------------------------------
module cffp_csr
   import cffp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output logic [6:0]                 source_limit,
   output logic [9:0]                 data_limit
);

   logic [6:0] source_limit_ff;
   logic [9:0] data_limit_ff;

   assign csr_ready = 1'b1;

   // Unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_limit_ff <= SOURCE_LIMIT_RESET;
         data_limit_ff   <= DATA_LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_SOURCE_LIMIT) begin
            source_limit_ff <= csr_data[6:0];
         end
         if (csr_index == REG_DATA_LIMIT) begin
            data_limit_ff <= csr_data[9:0];
         end
      end
   end

   assign source_limit = source_limit_ff;
   assign data_limit   = data_limit_ff;

endmodule

// File: design/cffp_step.sv
// ----------------------------------------------------------------------------
// cffp_step: per-byte parse stage
// Holds the frame phase, decimal accumulators and counters, and works out
// the next state and the result, if any, for the byte being transferred.
// ----------------------------------------------------------------------------
module cffp_step
   import cffp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_fire,
   input  logic [7:0]      byte_in,
   input  logic            frame_start,
   input  logic [6:0]      source_limit,
   input  logic [9:0]      data_limit,
   output logic            res_valid,
   output cffp_result_type res
);

   cffp_phase_type phase_ff, phase_in, phase_e;
   logic [15:0] type_acc_ff, type_acc_in, type_acc_e;
   logic [9:0]  size_acc_ff, size_acc_in, size_acc_e;
   logic [6:0]  src_cnt_ff, src_cnt_in, src_cnt_e;
   logic [9:0]  data_cnt_ff, data_cnt_in, data_cnt_e;
   logic        drop_ff, drop_in, drop_e;

   logic        is_digit;
   logic [3:0]  digit_val;
   logic [19:0] type_next;
   logic [13:0] size_next;
   logic [10:0] size_lim;
   logic [6:0]  src_lim;
   logic [7:0]  src_cnt_inc;
   logic [9:0]  data_cnt_inc;
   logic        hit;

   assign is_digit  = (byte_in >= 8'h30) && (byte_in <= 8'h39);
   assign digit_val = byte_in[3:0];

   // Frame start wipes the frame state before the byte is parsed.
   assign phase_e    = frame_start ? PH_TYPE : phase_ff;
   assign type_acc_e = frame_start ? 16'd0 : type_acc_ff;
   assign size_acc_e = frame_start ? 10'd0 : size_acc_ff;
   assign src_cnt_e  = frame_start ? 7'd0  : src_cnt_ff;
   assign data_cnt_e = frame_start ? 10'd0 : data_cnt_ff;
   assign drop_e     = frame_start ? 1'b0  : drop_ff;

   // acc * 10 + digit as two shifts and an add
   assign type_next = ({4'd0, type_acc_e} << 3) + ({4'd0, type_acc_e} << 1)
                      + {16'd0, digit_val};
   assign size_next = ({4'd0, size_acc_e} << 3) + ({4'd0, size_acc_e} << 1)
                      + {10'd0, digit_val};

   assign size_lim = ({1'b0, data_limit} > 11'(DATA_BYTES)) ? 11'(DATA_BYTES)
                                                             : {1'b0, data_limit};
   assign src_lim  = (source_limit > 7'(NAME_BYTES - 1)) ? 7'(NAME_BYTES - 1)
                                                         : source_limit;
   assign src_cnt_inc  = {1'b0, src_cnt_e} + 8'd1;
   assign data_cnt_inc = data_cnt_e + 10'd1;

   always_comb begin
      phase_in    = phase_e;
      type_acc_in = type_acc_e;
      size_acc_in = size_acc_e;
      src_cnt_in  = src_cnt_e;
      data_cnt_in = data_cnt_e;
      drop_in     = drop_e;
      hit         = 1'b0;

      res.kind          = KIND_SOURCE;
      res.byte_out      = 8'd0;
      res.msg_type      = type_acc_e;
      res.payload_size  = size_acc_e;
      res.source_length = src_cnt_e;
      res.error_code    = ERR_NON_DIGIT;
      res.frame_last    = 1'b0;

      if (!drop_e) begin
         unique case (phase_e)
            PH_IDLE: begin
            end
            PH_TYPE: begin
               if (byte_in == SEPARATOR) begin
                  phase_in = PH_SIZE;
               end else if (!is_digit) begin
                  hit            = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NON_DIGIT;
                  res.frame_last = 1'b1;
               end else if (type_next > TYPE_MAX) begin
                  hit            = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_OVER_LIMIT;
                  res.frame_last = 1'b1;
               end else begin
                  type_acc_in = type_next[15:0];
               end
            end
            PH_SIZE: begin
               if (byte_in == SEPARATOR) begin
                  phase_in = PH_SOURCE;
               end else if (!is_digit) begin
                  hit            = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NON_DIGIT;
                  res.frame_last = 1'b1;
               end else if (size_next > {3'd0, size_lim}) begin
                  hit            = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_OVER_LIMIT;
                  res.frame_last = 1'b1;
               end else begin
                  size_acc_in = size_next[9:0];
               end
            end
            PH_SOURCE: begin
               hit = 1'b1;
               if (byte_in == SEPARATOR) begin
                  res.kind = KIND_HEADER;
                  if (size_acc_e == 10'd0) begin
                     phase_in       = PH_IDLE;
                     res.frame_last = 1'b1;
                  end else begin
                     phase_in    = PH_DATA;
                     data_cnt_in = 10'd0;
                  end
               end else if (src_cnt_inc > {1'b0, src_lim}) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_SOURCE_LONG;
                  res.frame_last = 1'b1;
               end else begin
                  src_cnt_in        = src_cnt_inc[6:0];
                  res.byte_out      = byte_in;
                  res.source_length = src_cnt_inc[6:0];
               end
            end
            PH_DATA: begin
               hit          = 1'b1;
               data_cnt_in  = data_cnt_inc;
               res.kind     = KIND_DATA;
               res.byte_out = byte_in;
               if (data_cnt_inc >= size_acc_e) begin
                  phase_in       = PH_IDLE;
                  res.frame_last = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // Any error drops the rest of the frame.
         if (hit && (res.kind == KIND_ERROR)) begin
            phase_in = PH_IDLE;
            drop_in  = 1'b1;
         end
      end
   end

   assign res_valid = in_fire && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         type_acc_ff <= 16'd0;
         size_acc_ff <= 10'd0;
         src_cnt_ff  <= 7'd0;
         data_cnt_ff <= 10'd0;
         drop_ff     <= 1'b0;
      end else if (in_fire) begin
         phase_ff    <= phase_in;
         type_acc_ff <= type_acc_in;
         size_acc_ff <= size_acc_in;
         src_cnt_ff  <= src_cnt_in;
         data_cnt_ff <= data_cnt_in;
         drop_ff     <= drop_in;
      end
   end

endmodule

// File: design/cffp_out_buf.sv
// ----------------------------------------------------------------------------
// cffp_out_buf: result register with skid stage
// Presents results on the output channel and absorbs one extra result so
// the input side keeps taking bytes while a result waits.
// ----------------------------------------------------------------------------
module cffp_out_buf
   import cffp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cffp_result_type push_data,
   output logic            in_ready,
   output logic            out_valid,
   input  logic            out_ready,
   output cffp_result_type out_data
);

   logic            main_valid_ff;
   logic            skid_valid_ff;
   cffp_result_type main_ff;
   cffp_result_type skid_ff;
   logic            pop;

   assign pop      = main_valid_ff && out_ready;
   assign in_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no push can arrive while the skid stage is full
         if (pop) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff <= push_data;
         end else begin
            skid_ff <= push_data;
         end
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// File: design/colon_field_frame_parser_top.sv
// ----------------------------------------------------------------------------
// colon_field_frame_parser_top: chat frame body parser
// Parses "type:size:source:payload" frame bodies one byte per transfer.
// ----------------------------------------------------------------------------
// Each body byte is parsed in the cycle it is transferred and the block takes
// one byte per clock; the result, if any, appears on the rsp channel from a
// result register backed by a one-entry skid stage, so a stalled rsp side
// blocks req only once two results are waiting. Decimal type and size fields
// are converted to binary, source and payload bytes are passed through as
// kind 0 and 1, a header result (kind 2) closes the source field, and
// rsp_tlast marks the final result of a frame. A malformed field gives one
// error result (kind 3) and the rest of the frame is discarded until a byte
// with frame_start set. Limits are set through the csr channel:
// index 0 source length limit, index 1 payload size limit.
module colon_field_frame_parser_top
   import cffp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] byte_in
   input  logic                       req_tuser,   // [0] frame_start
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [7:0] byte_out, [23:8] msg_type, [33:24] payload_size,
   // [40:34] source_length, [42:41] error_code, [47:43] zero
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic [1:0]                 rsp_tuser,   // [1:0] kind
   output logic                       rsp_tlast,   // frame_last
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [6:0]      source_limit;
   logic [9:0]      data_limit;
   logic            in_fire;
   logic            res_valid;
   cffp_result_type res;
   cffp_result_type rsp;

   assign in_fire = req_tvalid && req_tready;

   cffp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .source_limit (source_limit),
      .data_limit   (data_limit)
   );

   cffp_step u_step (
      .clock        (clock),
      .reset        (reset),
      .in_fire      (in_fire),
      .byte_in      (req_tdata),
      .frame_start  (req_tuser),
      .source_limit (source_limit),
      .data_limit   (data_limit),
      .res_valid    (res_valid),
      .res          (res)
   );

   cffp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.error_code, rsp.source_length, rsp.payload_size,
                       rsp.msg_type, rsp.byte_out};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.frame_last;

endmodule
